FILE: rtl/three_level_page_map_defines.svh
// assertion macros for the page map checker
// no dependencies
`ifndef THREE_LEVEL_PAGE_MAP_DEFINES_SVH
`define THREE_LEVEL_PAGE_MAP_DEFINES_SVH
`define TLPM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");
`define TLPM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

FILE: rtl/tlpm_pkg.sv
// shared constants and types of the three-level page map
// no dependencies
package tlpm_pkg;
  localparam int TopBitsDef = 4;
  localparam int MidBitsDef = 4;
  localparam int LeafBitsDef = 6;
  localparam int MidPoolDef = 8;
  localparam int LeafPoolDef = 16;
  localparam int HandleWidthDef = 16;
  localparam int KeyW = 20;
  localparam int ValW = 16;
  localparam int LenW = 15;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0, ACT_STORE = 2'd1, ACT_PREALLOC = 2'd2, ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_RANGE = 2'd1, ST_NOPATH = 2'd2, ST_EXHAUST = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] page_key;
    logic [ValW-1:0] span_value;
    logic [LenW-1:0] range_length;
    logic            key_bad;
  } cmd_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic            found;
    logic [1:0]      status;
  } res_t;
endpackage

FILE: rtl/tlpm_if.sv
// valid/ready channel interfaces for commands and results
// depends on tlpm_pkg
interface tlpm_in_if (input logic clk);
  import tlpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  logic [KeyW-1:0] page_key;
  logic [ValW-1:0] span_value;
  logic [LenW-1:0] range_length;
  modport source (output valid, action, page_key, span_value, range_length, input ready);
  modport sink (input valid, action, page_key, span_value, range_length, output ready);
endinterface

interface tlpm_out_if (input logic clk);
  import tlpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] read_value;
  logic            found;
  logic [1:0]      status;
  modport source (output valid, read_value, found, status, input ready);
  modport sink (input valid, read_value, found, status, output ready);
endinterface

FILE: rtl/tlpm_front.sv
// front end: accepts items, checks key range, feeds a two-entry queue
// depends on tlpm_pkg
module tlpm_front #(
  parameter int TOTAL_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  tlpm_in_if.sink            in_ch,
  output tlpm_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  logic               cmd_take
);
  import tlpm_pkg::*;
  cmd_t q [2];
  logic [1:0] cnt;
  logic wr_ptr, rd_ptr;
  cmd_t c_in;
  logic push;

  always_comb begin
    c_in.action = in_ch.action;
    c_in.page_key = in_ch.page_key;
    c_in.span_value = in_ch.span_value;
    c_in.range_length = in_ch.range_length;
    c_in.key_bad = (TOTAL_BITS < KeyW) ? ((in_ch.page_key >> TOTAL_BITS) != '0) : 1'b0;
  end

  assign in_ch.ready = (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c_in;
    if (rst) begin
      cnt <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, cmd_take};
    end
  end
endmodule

FILE: rtl/tlpm_back.sv
// back end: walks the three table levels, allocates nodes, holds the result
// depends on tlpm_pkg
module tlpm_back #(
  parameter int TOP_BITS = 4,
  parameter int MID_BITS = 4,
  parameter int LEAF_BITS = 6,
  parameter int MID_POOL = 8,
  parameter int LEAF_POOL = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  tlpm_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_take,
  tlpm_out_if.source     out_ch
);
  import tlpm_pkg::*;
  localparam int TOTAL_BITS = TOP_BITS + MID_BITS + LEAF_BITS;
  localparam int TOP_SIZE = 1 << TOP_BITS;
  localparam int MN_W = (MID_POOL > 1) ? $clog2(MID_POOL) : 1;
  localparam int LF_W = (LEAF_POOL > 1) ? $clog2(LEAF_POOL) : 1;
  localparam int MU_W = $clog2(MID_POOL + 1);
  localparam int LU_W = $clog2(LEAF_POOL + 1);
  localparam int ME_W = MN_W + MID_BITS;
  localparam int SL_W = LF_W + LEAF_BITS;
  localparam int MID_DEPTH = MID_POOL << MID_BITS;
  localparam int LEAF_DEPTH = LEAF_POOL << LEAF_BITS;
  localparam int HW = (HANDLE_WIDTH < ValW) ? HANDLE_WIDTH : ValW;
  localparam int WK_W = KeyW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_MID, S_MIDRD, S_LEAF, S_LEAFRD, S_MCLR, S_LCLR, S_NEXT, S_DONE
  } state_t;

  state_t state;
  logic [TOP_SIZE-1:0] top_valid;
  logic [MN_W-1:0] top_node [TOP_SIZE];
  logic [MU_W-1:0] mid_used;
  logic [LU_W-1:0] leaf_used;
  // middle valid bits live in flops, cleared row by row when a node is taken
  logic [MID_DEPTH-1:0] mid_valid;
  logic [LF_W-1:0] mid_mem [MID_DEPTH];
  logic [HW-1:0] leaf_mem [LEAF_DEPTH];
  logic [LF_W-1:0] mid_rd;
  logic [HW-1:0] leaf_rd;

  cmd_t cur;
  logic [WK_W-1:0] key, key_end;
  logic [MN_W-1:0] mn;
  logic [ME_W-1:0] me;
  logic [LEAF_BITS-1:0] clr_cnt;
  res_t res;
  logic res_valid;

  logic [TOP_BITS-1:0] i1;
  logic [MID_BITS-1:0] i2;
  logic [LEAF_BITS-1:0] i3;
  logic prealloc;
  assign i1 = key[LEAF_BITS+MID_BITS +: TOP_BITS];
  assign i2 = key[LEAF_BITS +: MID_BITS];
  assign i3 = key[LEAF_BITS-1:0];
  assign prealloc = (cur.action == ACT_PREALLOC);

  assign cmd_take = (state == S_IDLE) && cmd_valid && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.read_value = res.read_value;
  assign out_ch.found = res.found;
  assign out_ch.status = res.status;

  logic mem_mid_we, mem_leaf_we;
  logic [ME_W-1:0] mid_wa;
  logic [LF_W-1:0] mid_wd;
  logic [SL_W-1:0] leaf_wa, leaf_ra;
  logic [HW-1:0] leaf_wd;

  always_comb begin
    mem_mid_we = 1'b0; mid_wa = me; mid_wd = leaf_used[LF_W-1:0];
    mem_leaf_we = 1'b0; leaf_wa = {mid_rd, i3}; leaf_wd = cur.span_value[HW-1:0];
    leaf_ra = {mid_rd, i3};
    if (state == S_LCLR) begin
      mem_leaf_we = 1'b1; leaf_wa = {mid_rd, clr_cnt}; leaf_wd = '0;
    end else if (state == S_LEAF && cur.action == ACT_STORE) begin
      mem_leaf_we = 1'b1;
    end
    if (state == S_MIDRD && prealloc && !mid_valid[me] && leaf_used < LU_W'(LEAF_POOL))
      mem_mid_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_mid_we) mid_mem[mid_wa] <= mid_wd;
    mid_rd <= mem_mid_we ? mid_wd : mid_mem[me];
    if (mem_leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    leaf_rd <= leaf_mem[leaf_ra];
  end

  task automatic finish(input logic [1:0] st);
    res.status <= st;
    state <= S_DONE;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top_valid <= '0;
      mid_used <= '0;
      leaf_used <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_take) begin
          cur <= cmd;
          key <= WK_W'(cmd.page_key);
          key_end <= WK_W'(cmd.page_key) + WK_W'(cmd.range_length);
          res.read_value <= '0;
          res.found <= 1'b0;
          // only lookups and stores check the key up front
          res.status <= (cmd.action != ACT_NONE && cmd.action != ACT_PREALLOC &&
                         cmd.key_bad) ? ST_RANGE : ST_OK;
          if (cmd.action == ACT_NONE) state <= S_DONE;
          else if (cmd.action == ACT_PREALLOC) state <= S_NEXT;
          else if (cmd.key_bad) state <= S_DONE;
          else state <= S_TOP;
        end
        S_NEXT: begin
          if (key >= key_end) finish(ST_OK);
          else if ((key >> TOTAL_BITS) != '0) finish(ST_RANGE);
          else state <= S_TOP;
        end
        S_TOP: begin
          if (!top_valid[i1]) begin
            if (!prealloc) finish(cur.action == ACT_STORE ? ST_NOPATH : ST_OK);
            else if (mid_used >= MU_W'(MID_POOL)) finish(ST_EXHAUST);
            else begin
              mn <= mid_used[MN_W-1:0];
              top_node[i1] <= mid_used[MN_W-1:0];
              top_valid[i1] <= 1'b1;
              mid_used <= mid_used + 1'b1;
              state <= S_MCLR;
            end
          end else begin
            mn <= top_node[i1];
            me <= {top_node[i1], i2};
            state <= S_MIDRD;
          end
        end
        S_MCLR: begin
          for (int j = 0; j < (1 << MID_BITS); j++)
            mid_valid[{mn, MID_BITS'(j)}] <= 1'b0;
          me <= {mn, i2};
          state <= S_MIDRD;
        end
        S_MIDRD: begin
          if (!mid_valid[me]) begin
            if (!prealloc) finish(cur.action == ACT_STORE ? ST_NOPATH : ST_OK);
            else if (leaf_used >= LU_W'(LEAF_POOL)) finish(ST_EXHAUST);
            else begin
              mid_valid[me] <= 1'b1;
              leaf_used <= leaf_used + 1'b1;
              clr_cnt <= '0;
              state <= S_LCLR;
            end
          end else state <= prealloc ? S_MID : S_LEAF;
        end
        S_MID: begin
          // leaf now present (found or just cleared), advance to next leaf boundary
          key <= ((key >> LEAF_BITS) + 1'b1) << LEAF_BITS;
          state <= S_NEXT;
        end
        S_LCLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_MID;
        end
        S_LEAF: begin
          if (cur.action == ACT_STORE) finish(ST_OK);
          else state <= S_LEAFRD;
        end
        S_LEAFRD: begin
          res.read_value <= ValW'(leaf_rd);
          res.found <= 1'b1;
          finish(ST_OK);
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/three_level_page_map.sv
// lookup: walks top and middle levels, then reads the leaf; store: writes the leaf entry;
// preallocate: takes nodes leaf by leaf, clearing each new leaf in an entry-by-entry sweep
// one item in the walker at a time; a two-entry queue takes items meanwhile
// reset clears top valid bits and pool counts directly, no clearing pass
module three_level_page_map #(
  parameter int TOP_BITS = tlpm_pkg::TopBitsDef,
  parameter int MID_BITS = tlpm_pkg::MidBitsDef,
  parameter int LEAF_BITS = tlpm_pkg::LeafBitsDef,
  parameter int MID_POOL = tlpm_pkg::MidPoolDef,
  parameter int LEAF_POOL = tlpm_pkg::LeafPoolDef,
  parameter int HANDLE_WIDTH = tlpm_pkg::HandleWidthDef
) (
  input logic clk,
  input logic rst,
  tlpm_in_if.sink    in_ch,
  tlpm_out_if.source out_ch
);
  import tlpm_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  tlpm_front #(.TOTAL_BITS(TOP_BITS + MID_BITS + LEAF_BITS)) u_front (
    .clk, .rst, .in_ch, .cmd, .cmd_valid, .cmd_take
  );

  tlpm_back #(
    .TOP_BITS(TOP_BITS), .MID_BITS(MID_BITS), .LEAF_BITS(LEAF_BITS),
    .MID_POOL(MID_POOL), .LEAF_POOL(LEAF_POOL), .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .out_ch
  );
endmodule

FILE: rtl/tlpm_checker.sv
// port-level checks of the page map, bound to the top level
// depends on three_level_page_map_defines.svh
`include "three_level_page_map_defines.svh"
module tlpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_value,
  input logic        found,
  input logic [1:0]  status
);
  `TLPM_ASSERT_IMP(a_nf_zero, clk, rst, out_valid && !found, read_value == 16'd0)
  `TLPM_ASSERT_IMP(a_found_ok, clk, rst, out_valid && found, status == 2'd0)
  `TLPM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `TLPM_ASSERT_NXT(a_no_back2back, clk, rst, out_valid && out_ready, !out_valid)
  `TLPM_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid)
endmodule

bind three_level_page_map tlpm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .read_value(out_ch.read_value),
  .found(out_ch.found), .status(out_ch.status)
);
